// ----- src/scle_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial console line editor package
// Function codes, character codes, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package scle_pkg;

  // Default number of entries in each byte queue.
  localparam int unsigned FifoDepthDefault = 64;

  // Register indexes of the configuration port.
  localparam int unsigned CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] CFG_ECHO_ENABLE    = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_SILENCE_ENABLE = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_SILENCE_BYTE   = 2'd2;
  localparam logic [CfgIndexW-1:0] CFG_SILENCE_TICKS  = 2'd3;

  // Character codes used by the line discipline.
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_LBR = 8'h5B;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;

  // Item function codes.
  typedef enum logic [2:0] {
    FUNC_LINE_RX  = 3'd0,
    FUNC_TX_READY = 3'd1,
    FUNC_READ     = 3'd2,
    FUNC_WRITE    = 3'd3,
    FUNC_RESUME   = 3'd4
  } func_e;

  // Per-item result flags handed from the engine to the result register.
  typedef struct packed {
    logic line_valid;
    logic read_valid;
    logic write_accepted;
  } flags_t;

endpackage

`default_nettype wire

// ----- src/scle_ram.sv -----
// ----------------------------------------------------------------------------
// Byte queue store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module scle_ram #(
  parameter int unsigned DEPTH = scle_pkg::FifoDepthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [7:0]               wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [7:0]               rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/scle_engine.sv -----
// ----------------------------------------------------------------------------
// Line discipline engine
// Holds configuration and queue state; one item per cycle when not busy.
// ----------------------------------------------------------------------------
`default_nettype none

module scle_engine #(
  parameter int unsigned FIFO_DEPTH = scle_pkg::FifoDepthDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [scle_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  wire logic [31:0]                         cfg_data_i,
  input  wire logic                                go_i,
  input  wire logic [2:0]                          func_i,
  input  wire logic [7:0]                          data_i,
  input  wire logic [31:0]                         now_tick_i,
  output logic                                     busy_o,
  output scle_pkg::flags_t                         flags_o,
  output logic                                     rx_we_o,
  output logic [$clog2(FIFO_DEPTH)-1:0]            rx_waddr_o,
  output logic [7:0]                               rx_wdata_o,
  output logic                                     rx_re_o,
  output logic [$clog2(FIFO_DEPTH)-1:0]            rx_raddr_o,
  output logic                                     tx_we_o,
  output logic [$clog2(FIFO_DEPTH)-1:0]            tx_waddr_o,
  output logic [7:0]                               tx_wdata_o,
  output logic                                     tx_re_o,
  output logic [$clog2(FIFO_DEPTH)-1:0]            tx_raddr_o,
  output logic [7:0]                               line_count_o,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]          rx_level_o,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]          tx_level_o,
  output logic                                     silenced_o,
  output logic [31:0]                              resume_tick_o
);

  localparam int unsigned PtrW   = $clog2(FIFO_DEPTH);
  localparam int unsigned LevelW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0]   PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [LevelW-1:0] Full    = LevelW'(FIFO_DEPTH);
  localparam logic [LevelW-1:0] Room2   = LevelW'(FIFO_DEPTH - 2);
  localparam logic [LevelW-1:0] Room3   = LevelW'(FIFO_DEPTH - 3);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  function automatic logic [PtrW-1:0] ptr_dec(input logic [PtrW-1:0] p);
    ptr_dec = (p == '0) ? PtrLast : p - PtrW'(1);
  endfunction

  // Configuration.
  logic        echo_en_q;
  logic        sil_en_q;
  logic [7:0]  sil_byte_q;
  logic [31:0] sil_ticks_q;

  // Queue and line state.
  logic [PtrW-1:0]   rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [PtrW-1:0]   tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [LevelW-1:0] rx_fill_q, rx_fill_d, tx_fill_q, tx_fill_d;
  logic [7:0]        last_q, last_d, prev_q, prev_d;
  logic [7:0]        lines_q, lines_d;
  logic              sil_q, sil_d;
  logic [31:0]       resume_q, resume_d;

  // Echo bytes still waiting for the transmit write port.
  logic [1:0] pend_cnt_q, pend_cnt_d;
  logic [7:0] pend0_q, pend0_d, pend1_q, pend1_d;

  logic             tx_push;
  logic [7:0]       tx_first;
  logic [1:0]       n_tx;
  logic             tx_pop;
  scle_pkg::flags_t flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_en_q   <= 1'b0;
      sil_en_q    <= 1'b0;
      sil_byte_q  <= '0;
      sil_ticks_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        scle_pkg::CFG_ECHO_ENABLE:    echo_en_q   <= cfg_data_i[0];
        scle_pkg::CFG_SILENCE_ENABLE: sil_en_q    <= cfg_data_i[0];
        scle_pkg::CFG_SILENCE_BYTE:   sil_byte_q  <= cfg_data_i[7:0];
        scle_pkg::CFG_SILENCE_TICKS:  sil_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic tx_has1;
    logic tx_has2;
    logic tx_has3;
    logic pass;

    tx_has1 = (tx_fill_q != Full);
    tx_has2 = (tx_fill_q <= Room2);
    tx_has3 = (tx_fill_q <= Room3);
    pass    = (last_q != scle_pkg::CH_LBR) && (prev_q != scle_pkg::CH_ESC) &&
              (data_i != scle_pkg::CH_ESC) && (data_i != scle_pkg::CH_LBR);

    rx_head_d  = rx_head_q;
    rx_tail_d  = rx_tail_q;
    rx_fill_d  = rx_fill_q;
    tx_head_d  = tx_head_q;
    last_d     = last_q;
    prev_d     = prev_q;
    lines_d    = lines_q;
    sil_d      = sil_q;
    resume_d   = resume_q;
    pend_cnt_d = pend_cnt_q;
    pend0_d    = pend0_q;
    pend1_d    = pend1_q;
    tx_push    = 1'b0;
    tx_first   = data_i;
    n_tx       = 2'd0;
    tx_pop     = 1'b0;
    flags      = '0;
    rx_we_o    = 1'b0;
    rx_re_o    = 1'b0;

    if (busy_o) begin
      // Drain one waiting echo byte a cycle.
      pend_cnt_d = pend_cnt_q - 2'd1;
      pend0_d    = pend1_q;
    end else if (go_i) begin
      case (scle_pkg::func_e'(func_i))
        scle_pkg::FUNC_LINE_RX: begin
          if (sil_en_q && (data_i == sil_byte_q)) begin
            if (!sil_q) begin
              sil_d    = 1'b1;
              resume_d = now_tick_i + sil_ticks_q;
            end
          end else begin
            prev_d = last_q;
            last_d = data_i;
            if (data_i inside {scle_pkg::CH_BS, scle_pkg::CH_DEL}) begin
              if (rx_fill_q != '0) begin
                rx_fill_d = rx_fill_q - LevelW'(1);
                rx_tail_d = ptr_dec(rx_tail_q);
                if (echo_en_q && tx_has1) begin
                  tx_push  = 1'b1;
                  tx_first = scle_pkg::CH_BS;
                  pend0_d  = scle_pkg::CH_SP;
                  pend1_d  = scle_pkg::CH_BS;
                  n_tx     = tx_has3 ? 2'd3 : (tx_has2 ? 2'd2 : 2'd1);
                  pend_cnt_d = n_tx - 2'd1;
                end
              end
            end else if (pass) begin
              if (((data_i == scle_pkg::CH_CR) ||
                   ((data_i == scle_pkg::CH_LF) && (last_q != scle_pkg::CH_CR))) &&
                  (lines_q != 8'hFF)) begin
                lines_d = lines_q + 8'd1;
              end
              if (rx_fill_q != Full) begin
                rx_we_o   = 1'b1;
                rx_tail_d = ptr_inc(rx_tail_q);
                rx_fill_d = rx_fill_q + LevelW'(1);
              end
              if (echo_en_q && tx_has1) begin
                tx_push = 1'b1;
                pend0_d = scle_pkg::CH_LF;
                if ((data_i == scle_pkg::CH_CR) && tx_has2) begin
                  n_tx       = 2'd2;
                  pend_cnt_d = 2'd1;
                end else begin
                  n_tx = 2'd1;
                end
              end
            end
          end
        end
        scle_pkg::FUNC_TX_READY: begin
          if (tx_fill_q != '0) begin
            tx_pop           = 1'b1;
            tx_head_d        = ptr_inc(tx_head_q);
            flags.line_valid = 1'b1;
          end
        end
        scle_pkg::FUNC_READ: begin
          if (rx_fill_q != '0) begin
            rx_re_o          = 1'b1;
            rx_head_d        = ptr_inc(rx_head_q);
            rx_fill_d        = rx_fill_q - LevelW'(1);
            flags.read_valid = 1'b1;
          end
        end
        scle_pkg::FUNC_WRITE: begin
          if (tx_has1) begin
            tx_push              = 1'b1;
            n_tx                 = 2'd1;
            flags.write_accepted = 1'b1;
          end
        end
        scle_pkg::FUNC_RESUME: begin
          sil_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign tx_fill_d = tx_fill_q + LevelW'(n_tx) - LevelW'(tx_pop);

  // The transmit store has one write port: a waiting echo byte has it first.
  assign busy_o     = (pend_cnt_q != 2'd0);
  assign tx_we_o    = busy_o || tx_push;
  assign tx_wdata_o = busy_o ? pend0_q : tx_first;
  assign tx_waddr_o = tx_tail_q;
  assign tx_tail_d  = tx_we_o ? ptr_inc(tx_tail_q) : tx_tail_q;
  assign tx_re_o    = tx_pop;
  assign tx_raddr_o = tx_head_q;

  assign rx_waddr_o = rx_tail_q;
  assign rx_wdata_o = data_i;
  assign rx_raddr_o = rx_head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q  <= '0;
      rx_tail_q  <= '0;
      rx_fill_q  <= '0;
      tx_head_q  <= '0;
      tx_tail_q  <= '0;
      tx_fill_q  <= '0;
      last_q     <= '0;
      prev_q     <= '0;
      lines_q    <= '0;
      sil_q      <= 1'b0;
      resume_q   <= '0;
      pend_cnt_q <= '0;
    end else begin
      rx_head_q  <= rx_head_d;
      rx_tail_q  <= rx_tail_d;
      rx_fill_q  <= rx_fill_d;
      tx_head_q  <= tx_head_d;
      tx_tail_q  <= tx_tail_d;
      tx_fill_q  <= tx_fill_d;
      last_q     <= last_d;
      prev_q     <= prev_d;
      lines_q    <= lines_d;
      sil_q      <= sil_d;
      resume_q   <= resume_d;
      pend_cnt_q <= pend_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend0_q <= pend0_d;
    pend1_q <= pend1_d;
  end

  assign flags_o       = flags;
  assign line_count_o  = lines_q;
  assign rx_level_o    = rx_fill_q;
  assign tx_level_o    = tx_fill_q;
  assign silenced_o    = sil_q;
  assign resume_tick_o = resume_q;

endmodule

`default_nettype wire

// ----- src/serial_console_line_editor.sv -----
// ----------------------------------------------------------------------------
// Serial console line editor
// Console line discipline with receive and transmit byte queues.
// ----------------------------------------------------------------------------
// An accepted item is registered, worked out once the engine and the result
// register are free, and its result is registered; a new item is taken
// every cycle while nothing stalls. The transmit store has a single write
// port: an erase that echoes backspace, space, backspace, and a carriage
// return echoed with an added line feed, hold the block while the extra
// echo bytes are written one per cycle. Status
// fields (line count, queue levels, silence state and resume tick) show the
// state after the item. Popped bytes come from the registered read of the
// queue stores, and read as zero when nothing was popped. Configuration may
// be written only while no item is in flight.
`default_nettype none

module serial_console_line_editor #(
  parameter int unsigned FIFO_DEPTH = scle_pkg::FifoDepthDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [scle_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  wire logic [31:0]                        cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [2:0]                         func_i,
  input  wire logic [7:0]                         data_i,
  input  wire logic [31:0]                        now_tick_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    line_valid_o,
  output logic [7:0]                              line_byte_o,
  output logic                                    read_valid_o,
  output logic [7:0]                              read_byte_o,
  output logic                                    write_accepted_o,
  output logic [7:0]                              line_count_o,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]         rx_level_o,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]         tx_level_o,
  output logic                                    silenced_o,
  output logic [31:0]                             resume_tick_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);

  // Input register.
  logic        in_valid_q;
  logic [2:0]  func_q;
  logic [7:0]  data_q;
  logic [31:0] now_q;

  // Result register.
  logic             out_valid_q;
  scle_pkg::flags_t flags_q;
  scle_pkg::flags_t flags;

  logic            busy;
  logic            go;
  logic            in_take;

  logic            rx_we, rx_re, tx_we, tx_re;
  logic [PtrW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [7:0]      rx_wdata, tx_wdata, rx_rdata, tx_rdata;

  // The registered item is worked out once the engine has no echo bytes
  // left to write and the result register is free or being emptied.
  assign go         = in_valid_q && !busy && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !go;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (go) begin
        in_valid_q <= 1'b0;
      end
      if (go) begin
        out_valid_q <= 1'b1;
        flags_q     <= flags;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q <= func_i;
      data_q <= data_i;
      now_q  <= now_tick_i;
    end
  end

  scle_engine #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .go_i          (go),
    .func_i        (func_q),
    .data_i        (data_q),
    .now_tick_i    (now_q),
    .busy_o        (busy),
    .flags_o       (flags),
    .rx_we_o       (rx_we),
    .rx_waddr_o    (rx_waddr),
    .rx_wdata_o    (rx_wdata),
    .rx_re_o       (rx_re),
    .rx_raddr_o    (rx_raddr),
    .tx_we_o       (tx_we),
    .tx_waddr_o    (tx_waddr),
    .tx_wdata_o    (tx_wdata),
    .tx_re_o       (tx_re),
    .tx_raddr_o    (tx_raddr),
    .line_count_o  (line_count_o),
    .rx_level_o    (rx_level_o),
    .tx_level_o    (tx_level_o),
    .silenced_o    (silenced_o),
    .resume_tick_o (resume_tick_o)
  );

  // Receive queue store.
  scle_ram #(
    .DEPTH (FIFO_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (rx_wdata),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  // Transmit queue store.
  scle_ram #(
    .DEPTH (FIFO_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  // The store read registers only load on a pop, so they hold with the
  // result register while the output is stalled.
  assign out_valid_o      = out_valid_q;
  assign line_valid_o     = flags_q.line_valid;
  assign line_byte_o      = flags_q.line_valid ? tx_rdata : 8'd0;
  assign read_valid_o     = flags_q.read_valid;
  assign read_byte_o      = flags_q.read_valid ? rx_rdata : 8'd0;
  assign write_accepted_o = flags_q.write_accepted;

endmodule

`default_nettype wire

// ----- src/scle_checker.sv -----
// ----------------------------------------------------------------------------
// Serial console line editor checker
// Port-level properties of the item streams, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scle_checker #(
  parameter int unsigned FIFO_DEPTH = scle_pkg::FifoDepthDefault
) (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic [2:0]                       func_i,
  input wire logic [7:0]                       data_i,
  input wire logic [31:0]                      now_tick_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic                             line_valid_o,
  input wire logic [7:0]                       line_byte_o,
  input wire logic                             read_valid_o,
  input wire logic [7:0]                       read_byte_o,
  input wire logic                             write_accepted_o,
  input wire logic [7:0]                       line_count_o,
  input wire logic [$clog2(FIFO_DEPTH+1)-1:0]  rx_level_o,
  input wire logic [$clog2(FIFO_DEPTH+1)-1:0]  tx_level_o,
  input wire logic                             silenced_o,
  input wire logic [31:0]                      resume_tick_o
);

  localparam logic [$clog2(FIFO_DEPTH+1)-1:0] Full = ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH);

  // A stalled input item keeps its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(func_i) && $stable(data_i) &&
      $stable(now_tick_i))
    else $error("stalled input item changed");

  // A stalled result holds all of its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_valid_o) &&
      $stable(line_byte_o) && $stable(read_valid_o) && $stable(read_byte_o) &&
      $stable(write_accepted_o) && $stable(line_count_o) && $stable(rx_level_o) &&
      $stable(tx_level_o) && $stable(silenced_o) && $stable(resume_tick_o))
    else $error("stalled result changed");

  // An item does at most one of pop to line, pop to consumer, or write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({line_valid_o, read_valid_o, write_accepted_o}) <= 1)
    else $error("more than one queue action in one result");

  // A byte field without its valid flag reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_valid_o || line_byte_o == 8'd0) &&
      (read_valid_o || read_byte_o == 8'd0))
    else $error("byte field not zero without valid flag");

  // Queue levels never pass the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rx_level_o <= Full && tx_level_o <= Full)
    else $error("queue level above depth");

endmodule

bind serial_console_line_editor scle_checker #(
  .FIFO_DEPTH (FIFO_DEPTH)
) u_scle_checker (.*);

`default_nettype wire

// ----- dv/tb_serial_console_line_editor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial console line editor testbench
// Drives directed and random items through the console block, predicts every
// result with an in-bench model of the two queues, the escape filter, the
// line counter and the silence logic, and checks each result in order.
// ----------------------------------------------------------------------------

module tb_serial_console_line_editor;

  localparam int unsigned Depth       = scle_pkg::FifoDepthDefault;
  localparam int unsigned LevelW      = $clog2(Depth + 1);
  localparam int          DrainCycles = 10;
  localparam int          QuietLimit  = 3000;
  localparam int          ReportMax   = 10;

  // Function codes that the block decodes as no-ops.
  localparam logic [2:0] FuncUnusedLo = 3'd5;
  localparam logic [2:0] FuncUnusedHi = 3'd7;

  // One result item, in port order.
  typedef struct packed {
    logic              line_valid;
    logic [7:0]        line_byte;
    logic              read_valid;
    logic [7:0]        read_byte;
    logic              write_accepted;
    logic [7:0]        line_count;
    logic [LevelW-1:0] rx_level;
    logic [LevelW-1:0] tx_level;
    logic              silenced;
    logic [31:0]       resume_tick;
  } status_t;

  localparam status_t IdleStatus = '0;

  // A directed row either offers one item or reprograms all four registers.
  // For a register row, data carries the silence byte and now the tick count.
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  func;
    logic [7:0]  data;
    logic [31:0] now;
    logic        echo;
    logic        sil_en;
    logic        typed;
    status_t     want;
  } row_t;

  localparam int PlanLen = 27;

  // The first rows run straight after reset with every register at zero, so
  // their results can be written down by hand. The rest are predicted.
  row_t plan [PlanLen] = '{
    '{ROW_ITEM, scle_pkg::FUNC_READ, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b1, IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_TX_READY, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, IdleStatus},
    '{ROW_ITEM, FuncUnusedLo, 8'h55, 32'h0000_0000, 1'b0, 1'b0, 1'b1, IdleStatus},
    '{ROW_ITEM, FuncUnusedHi, 8'hAA, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_WRITE, 8'hFF, 32'h0000_0000, 1'b0, 1'b0, 1'b1,
      '{write_accepted: 1'b1, tx_level: LevelW'(1), default: '0}},
    '{ROW_ITEM, scle_pkg::FUNC_TX_READY, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b1,
      '{line_valid: 1'b1, line_byte: 8'hFF, default: '0}},
    // Zero equals the silence byte, but silence handling is still off.
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, IdleStatus},
    // CR counts a line, LF right after it does not, a second LF does.
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, scle_pkg::CH_CR, 32'h0000_0001, 1'b0, 1'b0, 1'b0,
      IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, scle_pkg::CH_LF, 32'h0000_0002, 1'b0, 1'b0, 1'b0,
      IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, scle_pkg::CH_LF, 32'h0000_0003, 1'b0, 1'b0, 1'b0,
      IdleStatus},
    // Escape, bracket and the byte after the bracket are all filtered out.
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, scle_pkg::CH_ESC, 32'h0000_0004, 1'b0, 1'b0, 1'b0,
      IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, scle_pkg::CH_LBR, 32'h0000_0005, 1'b0, 1'b0, 1'b0,
      IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, 8'h41, 32'h0000_0006, 1'b0, 1'b0, 1'b0, IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, 8'h31, 32'h0000_0007, 1'b0, 1'b0, 1'b0, IdleStatus},
    // Both erase codes, with echo off.
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, scle_pkg::CH_BS, 32'h0000_0008, 1'b0, 1'b0, 1'b0,
      IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, scle_pkg::CH_DEL, 32'h0000_0009, 1'b0, 1'b0, 1'b0,
      IdleStatus},
    '{ROW_CFG, scle_pkg::FUNC_LINE_RX, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, IdleStatus},
    // The resume tick wraps; a second silence byte leaves it untouched.
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, 8'hFF, 32'h0000_0005, 1'b0, 1'b0, 1'b0, IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_RESUME, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, IdleStatus},
    // Echo on: CR gains an LF, erase echoes backspace, space, backspace.
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, scle_pkg::CH_CR, 32'h1234_5678, 1'b0, 1'b0, 1'b0,
      IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, 8'h80, 32'h8000_0000, 1'b0, 1'b0, 1'b0, IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_LINE_RX, scle_pkg::CH_BS, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0,
      IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_TX_READY, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_READ, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_WRITE, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, IdleStatus},
    '{ROW_ITEM, scle_pkg::FUNC_READ, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, IdleStatus}
  };

  // Clock, reset and every block input start at known values.
  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic [scle_pkg::CfgIndexW-1:0] cfg_index_i = '0;
  logic [31:0]       cfg_data_i   = '0;
  logic              in_valid_i   = 1'b0;
  logic [2:0]        func_i       = '0;
  logic [7:0]        data_i       = '0;
  logic [31:0]       now_tick_i   = '0;
  logic              out_stall_i  = 1'b0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic              line_valid_o;
  logic [7:0]        line_byte_o;
  logic              read_valid_o;
  logic [7:0]        read_byte_o;
  logic              write_accepted_o;
  logic [7:0]        line_count_o;
  logic [LevelW-1:0] rx_level_o;
  logic [LevelW-1:0] tx_level_o;
  logic              silenced_o;
  logic [31:0]       resume_tick_o;

  serial_console_line_editor #(
    .FIFO_DEPTH(Depth)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .data_i          (data_i),
    .now_tick_i      (now_tick_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .line_valid_o    (line_valid_o),
    .line_byte_o     (line_byte_o),
    .read_valid_o    (read_valid_o),
    .read_byte_o     (read_byte_o),
    .write_accepted_o(write_accepted_o),
    .line_count_o    (line_count_o),
    .rx_level_o      (rx_level_o),
    .tx_level_o      (tx_level_o),
    .silenced_o      (silenced_o),
    .resume_tick_o   (resume_tick_o)
  );

  // Traffic shaping, changed from phase to phase by the stimulus process.
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;

  // Results still owed by the block, oldest first.
  status_t pending_status [$];
  int      mismatch_count = 0;

  // Register copies and console state of the predictor.
  logic        echo_cfg;
  logic        silence_en_cfg;
  logic [7:0]  silence_code_cfg;
  logic [31:0] silence_len_cfg;

  logic [7:0]  rx_mem [Depth];
  logic [7:0]  tx_mem [Depth];
  int          rx_head_q, rx_fill_q, tx_head_q, tx_fill_q;
  logic [7:0]  prev_q, prev2_q, lines_q;
  logic        silence_q;
  logic [31:0] resume_q;

  initial begin
    echo_cfg = 1'b0;  silence_en_cfg = 1'b0;
    silence_code_cfg = '0;  silence_len_cfg = '0;
    rx_head_q = 0;  rx_fill_q = 0;  tx_head_q = 0;  tx_fill_q = 0;
    prev_q = '0;  prev2_q = '0;  lines_q = '0;
    silence_q = 1'b0;  resume_q = '0;
  end

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // A push onto the transmit queue is simply lost when the queue is full.
  function automatic logic tx_push(input logic [7:0] b);
    if (tx_fill_q >= Depth) return 1'b0;
    tx_mem[(tx_head_q + tx_fill_q) % Depth] = b;
    tx_fill_q++;
    return 1'b1;
  endfunction

  // Advances the predicted console state by one item and returns the status
  // that the block must report for it.
  function automatic status_t console_step(input logic [2:0] f, input logic [7:0] d,
                                           input logic [31:0] t);
    status_t r;
    r = IdleStatus;
    case (f)
      scle_pkg::FUNC_LINE_RX: begin
        if (silence_en_cfg && d == silence_code_cfg) begin
          // The silence byte is swallowed and does not enter the history.
          if (!silence_q) begin
            silence_q = 1'b1;
            resume_q  = t + silence_len_cfg;
          end
        end else begin
          if (d == scle_pkg::CH_BS || d == scle_pkg::CH_DEL) begin
            // Erasing only echoes when there was something to erase.
            if (rx_fill_q != 0) begin
              rx_fill_q--;
              if (echo_cfg) begin
                void'(tx_push(scle_pkg::CH_BS));
                void'(tx_push(scle_pkg::CH_SP));
                void'(tx_push(scle_pkg::CH_BS));
              end
            end
          end else if (prev_q != scle_pkg::CH_LBR && prev2_q != scle_pkg::CH_ESC &&
                       d != scle_pkg::CH_ESC && d != scle_pkg::CH_LBR) begin
            if ((d == scle_pkg::CH_CR || (d == scle_pkg::CH_LF && prev_q != scle_pkg::CH_CR))
                && lines_q != 8'hFF)
              lines_q++;
            if (rx_fill_q < Depth) begin
              rx_mem[(rx_head_q + rx_fill_q) % Depth] = d;
              rx_fill_q++;
            end
            // The added LF only goes in when the CR itself found room.
            if (echo_cfg && tx_push(d) && d == scle_pkg::CH_CR)
              void'(tx_push(scle_pkg::CH_LF));
          end
          prev2_q = prev_q;
          prev_q  = d;
        end
      end
      scle_pkg::FUNC_TX_READY: begin
        if (tx_fill_q != 0) begin
          r.line_valid = 1'b1;
          r.line_byte  = tx_mem[tx_head_q];
          tx_head_q    = (tx_head_q + 1) % Depth;
          tx_fill_q--;
        end
      end
      scle_pkg::FUNC_READ: begin
        if (rx_fill_q != 0) begin
          r.read_valid = 1'b1;
          r.read_byte  = rx_mem[rx_head_q];
          rx_head_q    = (rx_head_q + 1) % Depth;
          rx_fill_q--;
        end
      end
      scle_pkg::FUNC_WRITE:  r.write_accepted = tx_push(d);
      scle_pkg::FUNC_RESUME: silence_q = 1'b0;
      default: ;
    endcase
    r.line_count  = lines_q;
    r.rx_level    = LevelW'(rx_fill_q);
    r.tx_level    = LevelW'(tx_fill_q);
    r.silenced    = silence_q;
    r.resume_tick = resume_q;
    return r;
  endfunction

  function automatic string fmt_status(input status_t s);
    return $sformatf({"lv=%0d lb=%02h rv=%0d rb=%02h wa=%0d ",
                      "lines=%0d rx=%0d tx=%0d sil=%0d res=%08h"},
                     s.line_valid, s.line_byte, s.read_valid, s.read_byte,
                     s.write_accepted, s.line_count, s.rx_level, s.tx_level,
                     s.silenced, s.resume_tick);
  endfunction

  // Random line bytes lean towards line ends and the control codes that the
  // editor treats specially, the current silence byte among them.
  function automatic logic [7:0] pick_byte(input int cr_pct);
    logic [7:0] specials [7];
    int         r;
    specials = '{scle_pkg::CH_BS, scle_pkg::CH_DEL, scle_pkg::CH_ESC, scle_pkg::CH_LBR,
                 scle_pkg::CH_LF, scle_pkg::CH_SP, silence_code_cfg};
    r = $urandom_range(99);
    if (r < cr_pct) return ($urandom_range(3) == 0) ? scle_pkg::CH_LF : scle_pkg::CH_CR;
    if (r < cr_pct + 25) return specials[$urandom_range(6)];
    return 8'($urandom_range(255));
  endfunction

  // Offers one item, holding it steady until the block takes it, then
  // records what the block owes for it. A hand-written expectation, where a
  // row has one, stands in place of the predicted one.
  task automatic present_item(input logic [2:0] f, input logic [7:0] d,
                              input logic [31:0] t, input logic typed,
                              input status_t want);
    status_t got;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    data_i     <= d;
    now_tick_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = console_step(f, d, t);
    pending_status.push_back(typed ? want : got);
  endtask

  // Stops offering items and waits until the block has nothing in flight.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic reg_write(input logic [scle_pkg::CfgIndexW-1:0] idx,
                           input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic echo, input logic sil, input logic [7:0] code,
                              input logic [31:0] ticks);
    reg_write(scle_pkg::CFG_ECHO_ENABLE, 32'(echo));
    reg_write(scle_pkg::CFG_SILENCE_ENABLE, 32'(sil));
    reg_write(scle_pkg::CFG_SILENCE_BYTE, 32'(code));
    reg_write(scle_pkg::CFG_SILENCE_TICKS, ticks);
    cfg_we_i         <= 1'b0;
    echo_cfg         = echo;
    silence_en_cfg   = sil;
    silence_code_cfg = code;
    silence_len_cfg  = ticks;
  endtask

  // One random phase: registers, traffic shaping and the mix of item kinds.
  // Weights are percentages; what is left over goes to resume and the unused
  // function codes. Now and then a full escape sequence is sent in one go.
  task automatic run_phase(input int n, input int gap, input int stall, input int hold,
                           input logic echo, input logic sil, input logic [7:0] code,
                           input logic [31:0] ticks, input int rx_w, input int pop_w,
                           input int wr_w, input int cr_pct);
    int          r;
    logic [2:0]  f;
    logic [31:0] t;
    settle_block();
    program_regs(echo, sil, code, ticks);
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    hold_off_left  = hold;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      case ($urandom_range(7))
        0:       t = 32'hFFFF_FFFF;
        1:       t = 32'h0000_0000;
        default: t = $urandom();
      endcase
      if (r < rx_w && $urandom_range(7) == 0) begin
        present_item(scle_pkg::FUNC_LINE_RX, scle_pkg::CH_ESC, t, 1'b0, IdleStatus);
        present_item(scle_pkg::FUNC_LINE_RX, scle_pkg::CH_LBR, t, 1'b0, IdleStatus);
        present_item(scle_pkg::FUNC_LINE_RX, pick_byte(cr_pct), t, 1'b0, IdleStatus);
      end else begin
        if (r < rx_w) begin
          f = scle_pkg::FUNC_LINE_RX;
        end else if (r < rx_w + pop_w) begin
          f = $urandom_range(1) ? scle_pkg::FUNC_TX_READY : scle_pkg::FUNC_READ;
        end else if (r < rx_w + pop_w + wr_w) begin
          f = scle_pkg::FUNC_WRITE;
        end else if ($urandom_range(3) == 0) begin
          f = 3'($urandom_range(FuncUnusedLo, FuncUnusedHi));
        end else begin
          f = scle_pkg::FUNC_RESUME;
        end
        present_item(f, pick_byte(cr_pct), t, 1'b0, IdleStatus);
      end
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle_block();
        program_regs(plan[i].echo, plan[i].sil_en, plan[i].data, plan[i].now);
      end else begin
        present_item(plan[i].func, plan[i].data, plan[i].now, plan[i].typed, plan[i].want);
      end
    end

    // Back-to-back line ends with few reads: both queues fill up and the
    // line counter is driven towards saturation.
    run_phase(250, 0, 0, 0, 1'b1, 1'b0, 8'h00, 32'h0000_0000, 85, 10, 3, 70);
    // Sparse sender, echo off, silence on with random settings.
    run_phase(90, 86, 0, 0, 1'b0, 1'b1, 8'($urandom_range(255)), $urandom(),
              60, 15, 20, 20);
    // Reluctant receiver with plenty of consumer writes.
    run_phase(90, 0, 86, 0, 1'b1, 1'b1, 8'hFF, 32'hFFFF_FFFF, 40, 20, 35, 10);
    // Silence byte collides with DEL; the receiver also holds off for a long
    // stretch so that the block backs up and stalls its input.
    run_phase(90, 25, 25, 300, 1'b1, 1'b1, scle_pkg::CH_DEL, 32'h0000_0000, 60, 25, 10, 20);
    // Mostly pops, so both queues drain and empty pops are seen.
    run_phase(90, 0, 0, 0, 1'b0, 1'b0, 8'h00, 32'h0000_0000, 30, 60, 5, 10);
    run_phase(90, 25, 25, 0, 1'b1, 1'b1, 8'($urandom_range(255)), $urandom(),
              55, 30, 10, 20);

    settle_block();
    if (mismatch_count == 0 && pending_status.size() == 0)
      $display("tb_serial_console_line_editor: PASS");
    else
      $display("tb_serial_console_line_editor: FAIL");
    $finish;
  end

  // Receiver: a long hold-off when asked for, otherwise random stalls.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        out_stall_i <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    status_t seen;
    status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = {line_valid_o, line_byte_o, read_valid_o, read_byte_o, write_accepted_o,
              line_count_o, rx_level_o, tx_level_o, silenced_o, resume_tick_o};
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax)
          $display("%0t: unexpected result %s", $realtime, fmt_status(seen));
      end else begin
        want = pending_status.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected %s", fmt_status(want));
            $display("  actual   %s", fmt_status(seen));
          end
        end
      end
    end
  end

  // The run is abandoned once nothing has moved on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_serial_console_line_editor: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
src/scle_pkg.sv
src/scle_ram.sv
src/scle_engine.sv
src/serial_console_line_editor.sv
src/scle_checker.sv
dv/tb_serial_console_line_editor.sv
